[hw/rtl/tcfd_pkg.sv]
// tcfd_pkg: payload structs, record kind codes, frame ids and constant dividers
// shared by the telemetry frame decoder modules
// no dependencies
package tcfd_pkg;

	localparam int CountW    = 10;
	localparam int SlotW     = 9;
	localparam int KindCount = 15;
	localparam int KindIdxW  = 4;
	localparam int QDepth    = 2;
	localparam int QAw       = 1;

	// frame identifiers
	localparam logic [10:0] ID_HV     = 11'h0AA;
	localparam logic [10:0] ID_PEDAL  = 11'h0B0;
	localparam logic [10:0] ID_IMU    = 11'h0C0;
	localparam logic [10:0] ID_GPS    = 11'h0D0;
	localparam logic [10:0] ID_LV     = 11'h0FF;
	localparam logic [10:0] ID_MARKER = 11'h0AB;

	// subtypes
	localparam logic [7:0] SUB_00 = 8'h00;
	localparam logic [7:0] SUB_01 = 8'h01;
	localparam logic [7:0] SUB_02 = 8'h02;
	localparam logic [7:0] SUB_05 = 8'h05;
	localparam logic [7:0] SUB_06 = 8'h06;
	localparam logic [7:0] SUB_08 = 8'h08;
	localparam logic [7:0] SUB_09 = 8'h09;
	localparam logic [7:0] SUB_0A = 8'h0A;

	// record kinds
	localparam logic [4:0] KIND_NONE      = 5'd0;
	localparam logic [4:0] KIND_HV_VOLT   = 5'd1;
	localparam logic [4:0] KIND_HV_TEMP   = 5'd2;
	localparam logic [4:0] KIND_HV_CURR   = 5'd3;
	localparam logic [4:0] KIND_HV_ERR    = 5'd4;
	localparam logic [4:0] KIND_HV_WARN   = 5'd5;
	localparam logic [4:0] KIND_THROTTLE  = 5'd6;
	localparam logic [4:0] KIND_BRAKE     = 5'd7;
	localparam logic [4:0] KIND_GYRO      = 5'd8;
	localparam logic [4:0] KIND_ACCEL     = 5'd9;
	localparam logic [4:0] KIND_STEER     = 5'd10;
	localparam logic [4:0] KIND_GPS_LAT   = 5'd11;
	localparam logic [4:0] KIND_GPS_LON   = 5'd12;
	localparam logic [4:0] KIND_WHEELS    = 5'd13;
	localparam logic [4:0] KIND_DISTANCE  = 5'd14;
	localparam logic [4:0] KIND_LV        = 5'd15;
	localparam logic [4:0] KIND_MARKER    = 5'd16;

	typedef struct packed {
		logic [10:0] frame_id;
		logic [31:0] payload_high;
		logic [31:0] payload_low;
		logic [31:0] arrival_ms;
	} frame_t;

	typedef struct packed {
		logic [4:0]  record_kind;
		logic [8:0]  slot_index;
		logic        recorded;
		logic        overflow;
		logic [31:0] stamp_ms;
		logic [15:0] value_a;
		logic [15:0] value_b;
		logic [15:0] value_c;
		logic [15:0] value_d;
		logic        marker_seen;
	} record_t;

	// classified frame, queued between front and back
	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] stamp;
		logic [15:0] va;
		logic [15:0] vb;
		logic [15:0] vc;
		logic [15:0] vd;
	} dec_t;

	// reciprocal multiply dividers, exact over the full input range
	function automatic logic [10:0] div10000_24(input logic [23:0] x);
		logic [48:0] p;
		p = 49'(x) * 49'd27487791;
		return p[48:38];
	endfunction

	function automatic logic [9:0] div100_16(input logic [15:0] x);
		logic [32:0] p;
		p = 33'(x) * 33'd83887;
		return p[32:23];
	endfunction

	function automatic logic [12:0] div10_16(input logic [15:0] x);
		logic [31:0] p;
		p = 32'(x) * 32'd52429;
		return p[31:19];
	endfunction

	function automatic logic [13:0] div5_16(input logic [15:0] x);
		logic [31:0] p;
		p = 32'(x) * 32'd52429;
		return p[31:18];
	endfunction

endpackage

[hw/rtl/tcfd_front.sv]
// tcfd_front: classifies a CAN frame and decodes its value fields
// depends on tcfd_pkg
module tcfd_front import tcfd_pkg::*; (
	input  frame_t frame,
	output dec_t   dec
);

	logic [10:0] id;
	logic [31:0] h;
	logic [31:0] l;
	logic [7:0]  sub;
	logic [15:0] mid;
	logic [15:0] m256;
	logic [16:0] m255_w;
	logic [15:0] m255;

	logic [15:0] hv_v_a, hv_v_b, hv_v_c;
	logic [15:0] hv_t_a, hv_t_b, hv_t_c;
	logic [15:0] hv_c_a, hb1_div10, lb3_div10;
	logic [15:0] lv_a, lv_b;

	assign id   = frame.frame_id;
	assign h    = frame.payload_high;
	assign l    = frame.payload_low;
	assign sub  = h[31:24];
	assign mid  = h[23:8];
	assign m256 = {h[7:0], l[31:24]};
	// high byte times 255 plus low byte
	assign m255_w = {1'b0, h[7:0], 8'h00} - 17'(h[7:0]) + 17'(l[31:24]);
	assign m255   = m255_w[15:0];

	assign hv_v_a    = 16'(div10000_24(h[23:0]));
	assign hv_v_b    = 16'(div10000_24(24'(l[31:16])));
	assign hv_v_c    = 16'(div10000_24(24'(l[15:0])));
	assign hv_t_a    = 16'(div100_16(mid));
	assign hv_t_b    = 16'(div100_16(m256));
	assign hv_t_c    = 16'(div100_16(l[31:16]));
	assign hv_c_a    = 16'(div10_16(mid));
	assign hb1_div10 = 16'(div10_16(16'(h[15:8])));
	assign lb3_div10 = 16'(div10_16(16'(l[31:24])));
	// q8.8 with rounding to nearest
	assign lv_a      = 16'(div10_16({h[31:24], 8'd5}));
	assign lv_b      = 16'(div5_16({h[15:8], 8'd2}));

	always_comb begin
		dec = '0;
		case (id)
			ID_HV: begin
				case (sub)
					SUB_01: begin
						dec.kind = KIND_HV_VOLT;
						dec.va = hv_v_a;
						dec.vb = hv_v_b;
						dec.vc = hv_v_c;
					end
					SUB_0A: begin
						dec.kind = KIND_HV_TEMP;
						dec.va = hv_t_a;
						dec.vb = hv_t_b;
						dec.vc = hv_t_c;
					end
					SUB_05: begin
						dec.kind = KIND_HV_CURR;
						dec.va = hv_c_a;
						dec.vb = m256;
					end
					SUB_08, SUB_09: begin
						dec.kind = (sub == SUB_08) ? KIND_HV_ERR : KIND_HV_WARN;
						dec.va = 16'(h[23:16]);
						dec.vb = hb1_div10;
					end
					default: dec.kind = KIND_NONE;
				endcase
			end
			ID_PEDAL: begin
				case (sub)
					SUB_01, SUB_02: begin
						dec.kind = (sub == SUB_01) ? KIND_THROTTLE : KIND_BRAKE;
						dec.va = 16'(h[23:16]);
					end
					default: dec.kind = KIND_NONE;
				endcase
			end
			ID_IMU: begin
				case (sub)
					SUB_00, SUB_05: begin
						dec.kind = (sub == SUB_00) ? KIND_GYRO : KIND_ACCEL;
						dec.va = mid;
						dec.vb = m255;
						dec.vc = l[23:8];
						dec.vd = (sub == SUB_00) ? lb3_div10 : 16'(l[31:24]);
					end
					SUB_02: begin
						dec.kind = KIND_STEER;
						dec.va = 16'(h[23:16]);
					end
					default: dec.kind = KIND_NONE;
				endcase
			end
			ID_GPS: begin
				case (sub)
					SUB_01, SUB_02: begin
						dec.kind = (sub == SUB_01) ? KIND_GPS_LAT : KIND_GPS_LON;
						dec.va = mid;
						dec.vb = m255;
						dec.vc = 16'(l[23:16]);
						dec.vd = l[15:0];
					end
					SUB_06: begin
						dec.kind = KIND_WHEELS;
						dec.va = mid;
					end
					SUB_08: begin
						dec.kind = KIND_DISTANCE;
						dec.va = mid;
						dec.vb = m255;
						dec.vc = 16'(l[19:16]);
						dec.vd = 16'(l[11:8]);
					end
					default: dec.kind = KIND_NONE;
				endcase
			end
			ID_LV: begin
				dec.kind = KIND_LV;
				dec.va = lv_a;
				dec.vb = lv_b;
			end
			ID_MARKER: dec.kind = KIND_MARKER;
			default: dec.kind = KIND_NONE;
		endcase
		if (dec.kind != KIND_NONE) begin
			dec.stamp = frame.arrival_ms;
		end
	end

endmodule

[hw/rtl/tcfd_queue.sv]
// tcfd_queue: two-entry queue of classified frames between front and back
// depends on tcfd_pkg
module tcfd_queue import tcfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  dec_t push_data,
	output logic full,
	output logic pop_valid,
	input  logic pop,
	output dec_t pop_data
);

	localparam int CntW = $clog2(QDepth + 1);

	dec_t            mem_q [QDepth];
	logic [QAw-1:0]  wr_ptr_q;
	logic [QAw-1:0]  rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full      = (cnt_q == CntW'(QDepth));
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hw/rtl/tcfd_back.sv]
// tcfd_back: per-kind slot counters, marker flag and the output register
// depends on tcfd_pkg
module tcfd_back import tcfd_pkg::*; #(
	parameter int SLOTS = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CountW-1:0] cfg_wdata,
	input  logic              q_valid,
	input  dec_t              q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output record_t           out_data
);

	localparam logic [CountW-1:0] SlotLim = CountW'(SLOTS);

	logic [CountW-1:0]   limit_q;
	logic [CountW-1:0]   counts_q [KindCount];
	logic                marker_q;
	logic                out_valid_q;
	record_t             out_data_q;

	logic                is_rec;
	logic [4:0]          kind_m1;
	logic [KindIdxW-1:0] idx;
	logic [CountW-1:0]   cnt;
	logic [CountW-1:0]   lim;
	logic                room;
	logic                marker_nxt;
	record_t             rec;

	assign q_pop     = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign is_rec  = (q_data.kind != KIND_NONE) && (q_data.kind != KIND_MARKER);
	assign kind_m1 = q_data.kind - 5'd1;
	assign idx     = kind_m1[KindIdxW-1:0];
	assign cnt     = counts_q[idx];
	assign lim     = (limit_q < SlotLim) ? limit_q : SlotLim;
	assign room    = cnt < lim;
	assign marker_nxt = marker_q || (q_data.kind == KIND_MARKER);

	always_comb begin
		rec             = '0;
		rec.record_kind = q_data.kind;
		rec.stamp_ms    = q_data.stamp;
		rec.value_a     = q_data.va;
		rec.value_b     = q_data.vb;
		rec.value_c     = q_data.vc;
		rec.value_d     = q_data.vd;
		rec.marker_seen = marker_nxt;
		if (is_rec) begin
			rec.recorded   = room;
			rec.overflow   = !room;
			rec.slot_index = room ? cnt[SlotW-1:0] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_data_q <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= CountW'(500);
			marker_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < KindCount; i++) begin
				counts_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (q_pop) begin
				marker_q    <= marker_nxt;
				out_valid_q <= 1'b1;
				if (is_rec && room) begin
					counts_q[idx] <= cnt + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/telemetry_can_frame_decoder.sv]
// telemetry_can_frame_decoder: top level, front decoder, queue and back end
// depends on tcfd_pkg, tcfd_front, tcfd_queue, tcfd_back
//
// channel  | direction | handshake             | beat payload
// ---------+-----------+-----------------------+------------------------------
// in       | in        | in_valid / in_ready   | frame_t: id, two words, time
// out      | out       | out_valid / out_ready | record_t: kind, slot, values
// cfg      | in        | cfg_we                | cfg_wdata: buffer_limit
//
// one frame per cycle sustained while out keeps accepting; an accepted beat is decoded
// into the queue and moves on to the out register when out is free
// the dividers are reciprocal multipliers in the front, one per divided field
// reset clears the queue, the slot counters and the marker flag and sets the limit to 500
// in_ready drops only when the two-entry queue fills behind a stalled out beat
module telemetry_can_frame_decoder import tcfd_pkg::*; #(
	parameter int SLOTS = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  frame_t            in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output record_t           out_data,
	input  logic              cfg_we,
	input  logic [CountW-1:0] cfg_wdata
);

	dec_t dec;
	dec_t q_data;
	logic q_full;
	logic q_valid;
	logic q_pop;
	logic push;

	// front: classify the frame and decode its fields in the accept cycle
	tcfd_front u_front (
		.frame (in_data),
		.dec   (dec)
	);

	// accept whenever the queue has room
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	tcfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (dec),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_data  (q_data)
	);

	// back: slot allocation per kind, overflow, sticky marker, out register
	tcfd_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a record is never both stored and dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.recorded && out_data.overflow))
		else $error("recorded and overflow both set");

	// only real kinds take a slot or overflow
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.recorded || out_data.overflow) |->
			(out_data.record_kind != KIND_NONE) && (out_data.record_kind != KIND_MARKER))
		else $error("slot activity on none or marker kind");

	// a full queue means the out register holds a waiting beat
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("queue full with empty out register");

	// marker flag never clears once reported
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.marker_seen |=>
			!out_valid || out_data.marker_seen)
		else $error("marker flag cleared");

endmodule

[bench/tcfd_record_checker.sv]
// tcfd_record_checker: watches the frame and record channels of the telemetry frame decoder,
// predicts each record and compares it field by field against the output beats
// depends on tcfd_pkg
module tcfd_record_checker import tcfd_pkg::*; #(
	parameter int SLOTS = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  frame_t            in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  record_t           out_data,
	input  logic              cfg_we,
	input  logic [CountW-1:0] cfg_wdata,
	output int                fail_count,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CountW-1:0] LIMIT_AT_RESET = 10'd500;
	localparam int                REPORT_MAX     = 10;

	logic [CountW-1:0] kind_slots [KindCount];
	logic              marker_latched;
	logic [CountW-1:0] buffer_limit;
	record_t           pending_records [$];
	int                mismatches = 0;

	assign fail_count = mismatches;

	// decode one frame and advance the slot counters and the marker flag
	function automatic record_t decode_frame(input frame_t f);
		record_t           r;
		logic [31:0]       h;
		logic [31:0]       l;
		logic [7:0]        sub;
		logic [15:0]       mid;
		logic [15:0]       merge255;
		logic [15:0]       merge256;
		logic [CountW-1:0] lim;
		int unsigned       k;
		r        = '0;
		h        = f.payload_high;
		l        = f.payload_low;
		sub      = h[31:24];
		mid      = h[23:8];
		merge255 = 16'(h[7:0] * 255 + l[31:24]);
		merge256 = {h[7:0], l[31:24]};
		case (f.frame_id)
			ID_HV: begin
				case (sub)
					SUB_01: begin
						r.record_kind = KIND_HV_VOLT;
						r.value_a     = 16'(h[23:0] / 10000);
						r.value_b     = 16'(l[31:16] / 10000);
						r.value_c     = 16'(l[15:0] / 10000);
					end
					SUB_0A: begin
						r.record_kind = KIND_HV_TEMP;
						r.value_a     = 16'(mid / 100);
						r.value_b     = 16'(merge256 / 100);
						r.value_c     = 16'(l[31:16] / 100);
					end
					SUB_05: begin
						r.record_kind = KIND_HV_CURR;
						r.value_a     = 16'(mid / 10);
						r.value_b     = merge256;
					end
					SUB_08, SUB_09: begin
						r.record_kind = (sub == SUB_08) ? KIND_HV_ERR : KIND_HV_WARN;
						r.value_a     = 16'(h[23:16]);
						r.value_b     = 16'(h[15:8] / 10);
					end
					default: ;
				endcase
			end
			ID_PEDAL: begin
				if (sub == SUB_01 || sub == SUB_02) begin
					r.record_kind = (sub == SUB_01) ? KIND_THROTTLE : KIND_BRAKE;
					r.value_a     = 16'(h[23:16]);
				end
			end
			ID_IMU: begin
				if (sub == SUB_00 || sub == SUB_05) begin
					r.record_kind = (sub == SUB_00) ? KIND_GYRO : KIND_ACCEL;
					r.value_a     = mid;
					r.value_b     = merge255;
					r.value_c     = l[23:8];
					r.value_d     = (sub == SUB_00) ? 16'(l[31:24] / 10) : 16'(l[31:24]);
				end else if (sub == SUB_02) begin
					r.record_kind = KIND_STEER;
					r.value_a     = 16'(h[23:16]);
				end
			end
			ID_GPS: begin
				case (sub)
					SUB_01, SUB_02: begin
						r.record_kind = (sub == SUB_01) ? KIND_GPS_LAT : KIND_GPS_LON;
						r.value_a     = mid;
						r.value_b     = merge255;
						r.value_c     = 16'(l[23:16]);
						r.value_d     = l[15:0];
					end
					SUB_06: begin
						r.record_kind = KIND_WHEELS;
						r.value_a     = {h[23:16], h[15:8]};
					end
					SUB_08: begin
						r.record_kind = KIND_DISTANCE;
						r.value_a     = mid;
						r.value_b     = merge255;
						r.value_c     = 16'(l[19:16]);
						r.value_d     = 16'(l[11:8]);
					end
					default: ;
				endcase
			end
			ID_LV: begin
				// q8.8, rounded to nearest
				r.record_kind = KIND_LV;
				r.value_a     = 16'((h[31:24] * 256 + 5) / 10);
				r.value_b     = 16'((h[15:8] * 256 + 2) / 5);
			end
			ID_MARKER: begin
				r.record_kind  = KIND_MARKER;
				marker_latched = 1'b1;
			end
			default: ;
		endcase

		if (r.record_kind != KIND_NONE)
			r.stamp_ms = f.arrival_ms;

		if (r.record_kind != KIND_NONE && r.record_kind != KIND_MARKER) begin
			k   = r.record_kind - 1;
			lim = (buffer_limit < SLOTS) ? buffer_limit : CountW'(SLOTS);
			if (kind_slots[k] < lim) begin
				r.slot_index  = kind_slots[k][SlotW-1:0];
				r.recorded    = 1'b1;
				kind_slots[k] = kind_slots[k] + 1'b1;
			end else begin
				r.overflow = 1'b1;
			end
		end
		r.marker_seen = marker_latched;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (kind_slots[i])
				kind_slots[i] = '0;
			marker_latched = 1'b0;
			buffer_limit   = LIMIT_AT_RESET;
			pending_records.delete();
			pending <= 0;
		end else begin
			record_t want;
			if (cfg_we)
				buffer_limit = cfg_wdata;
			if (out_valid && out_ready) begin
				if (pending_records.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t ns: record beat with nothing expected, got %h", $time,
							out_data);
				end else begin
					want = pending_records.pop_front();
					check_field("record_kind", 32'(out_data.record_kind),
						32'(want.record_kind));
					check_field("slot_index", 32'(out_data.slot_index), 32'(want.slot_index));
					check_field("recorded", 32'(out_data.recorded), 32'(want.recorded));
					check_field("overflow", 32'(out_data.overflow), 32'(want.overflow));
					check_field("stamp_ms", out_data.stamp_ms, want.stamp_ms);
					check_field("value_a", 32'(out_data.value_a), 32'(want.value_a));
					check_field("value_b", 32'(out_data.value_b), 32'(want.value_b));
					check_field("value_c", 32'(out_data.value_c), 32'(want.value_c));
					check_field("value_d", 32'(out_data.value_d), 32'(want.value_d));
					check_field("marker_seen", 32'(out_data.marker_seen),
						32'(want.marker_seen));
				end
			end
			if (in_valid && in_ready)
				pending_records.push_back(decode_frame(in_data));
			pending <= pending_records.size();
		end
	end

endmodule

[bench/telemetry_can_frame_decoder_tb.sv]
// telemetry_can_frame_decoder_tb: frame stimulus, record sink and verdict for the decoder
// depends on tcfd_pkg, telemetry_can_frame_decoder and tcfd_record_checker
module telemetry_can_frame_decoder_tb;
	import tcfd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// watchdog limit, a wide margin over the slowest correct run
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 80;
	localparam int IDLE_MAX    = 8;
	localparam int SLOTS_TOP   = 512;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	frame_t            in_data   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	record_t           out_data;
	logic              cfg_we    = 1'b0;
	logic [CountW-1:0] cfg_wdata = '0;

	int fail_count;
	int pending;
	int cycle_count = 0;

	// idle knobs, changed between phases
	int frame_gap_max  = IDLE_MAX;
	int record_gap_max = IDLE_MAX;
	int hold_cycles    = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	telemetry_can_frame_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	tcfd_record_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// record sink: random stall before each beat, or one long hold when asked
	initial begin : record_sink
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				stall       = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = $urandom_range(0, record_gap_max);
			end
			// only drop ready when a stall follows, so ready never toggles within one step
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// offer one frame beat after a random gap, return at the edge that accepts it
	task automatic send_frame(input frame_t f);
		int gap;
		gap = $urandom_range(0, frame_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= f;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// stop offering and wait until every predicted record has been seen;
	// pending is registered, so look from the edge after the last accepted frame
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// buffer_limit write, only with the decoder drained
	task automatic write_limit(input logic [CountW-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly well-formed frames (known id with a listed subtype), the rest
	// unlisted subtypes on known ids and fully random identifiers
	function automatic frame_t random_frame();
		frame_t      f;
		logic [7:0]  sub;
		int unsigned pick;
		f.frame_id     = 11'($urandom());
		f.payload_high = $urandom();
		f.payload_low  = $urandom();
		f.arrival_ms   = $urandom();
		pick           = $urandom_range(0, 99);
		if (pick < 90) begin
			sub = f.payload_high[31:24];
			case ($urandom_range(0, 5))
				0: begin
					f.frame_id = ID_HV;
					case ($urandom_range(0, 4))
						0:       sub = SUB_01;
						1:       sub = SUB_0A;
						2:       sub = SUB_05;
						3:       sub = SUB_08;
						default: sub = SUB_09;
					endcase
				end
				1: begin
					f.frame_id = ID_PEDAL;
					sub        = $urandom_range(0, 1) ? SUB_01 : SUB_02;
				end
				2: begin
					f.frame_id = ID_IMU;
					case ($urandom_range(0, 2))
						0:       sub = SUB_00;
						1:       sub = SUB_05;
						default: sub = SUB_02;
					endcase
				end
				3: begin
					f.frame_id = ID_GPS;
					case ($urandom_range(0, 3))
						0:       sub = SUB_01;
						1:       sub = SUB_02;
						2:       sub = SUB_06;
						default: sub = SUB_08;
					endcase
				end
				4:       f.frame_id = ID_LV;
				default: f.frame_id = ID_MARKER;
			endcase
			// noise share keeps the random subtype byte on a known id
			if (pick < 80)
				f.payload_high[31:24] = sub;
		end
		return f;
	endfunction

	task automatic send_random(input int count);
		repeat (count)
			send_frame(random_frame());
	endtask

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats at the reset limit: every kind with extreme payloads,
		// unlisted subtypes, unknown ids and a repeated marker
		send_frame(frame_t'{ID_HV, 32'h01FF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_frame(frame_t'{ID_HV, 32'h0100_0000, 32'h0000_0000, 32'h0000_0000});
		send_frame(frame_t'{ID_HV, 32'h0AFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001});
		send_frame(frame_t'{ID_HV, 32'h05FF_FFFF, 32'hFFFF_FFFF, 32'h0000_0002});
		send_frame(frame_t'{ID_HV, 32'h08FF_FFFF, 32'h0000_0000, 32'h0000_0003});
		send_frame(frame_t'{ID_HV, 32'h09FF_FFFF, 32'h0000_0000, 32'h0000_0004});
		send_frame(frame_t'{ID_PEDAL, 32'h01FF_0000, 32'h0000_0000, 32'h0000_0005});
		send_frame(frame_t'{ID_PEDAL, 32'h0280_0000, 32'hFFFF_FFFF, 32'h0000_0006});
		send_frame(frame_t'{ID_IMU, 32'h00FF_FFFF, 32'hFFFF_FFFF, 32'h0000_0007});
		send_frame(frame_t'{ID_IMU, 32'h05FF_FFFF, 32'hFFFF_FFFF, 32'h0000_0008});
		send_frame(frame_t'{ID_IMU, 32'h02FF_FFFF, 32'h0000_0000, 32'h0000_0009});
		send_frame(frame_t'{ID_GPS, 32'h01FF_FFFF, 32'hFFFF_FFFF, 32'h0000_000A});
		send_frame(frame_t'{ID_GPS, 32'h0200_0000, 32'h0000_0000, 32'h0000_000B});
		send_frame(frame_t'{ID_GPS, 32'h06FF_FFFF, 32'h0000_0000, 32'h0000_000C});
		send_frame(frame_t'{ID_GPS, 32'h08FF_FFFF, 32'hFFFF_FFFF, 32'h0000_000D});
		send_frame(frame_t'{ID_LV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_frame(frame_t'{ID_LV, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
		send_frame(frame_t'{ID_HV, 32'h07FF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_frame(frame_t'{ID_PEDAL, 32'h0000_0000, 32'h0000_0000, 32'h0000_0010});
		send_frame(frame_t'{ID_IMU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_frame(frame_t'{ID_GPS, 32'h03FF_FFFF, 32'hFFFF_FFFF, 32'h0000_0011});
		send_frame(frame_t'{11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_frame(frame_t'{11'h000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
		send_frame(frame_t'{ID_MARKER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_frame(frame_t'{ID_MARKER, 32'h0000_0000, 32'h0000_0000, 32'h0000_0012});

		// zero limit: every counted kind overflows
		write_limit('0);
		send_random(100);

		// small limit, the counters saturate quickly; one long hold on the sink
		// while frames keep coming back to back, so the queue fills and in_ready drops
		write_limit(CountW'($urandom_range(2, 8)));
		frame_gap_max = 0;
		hold_cycles   = LONG_HOLD;
		send_random(40);
		frame_gap_max = IDLE_MAX;
		send_random(110);

		// top of the range, a stretch with no idling on either side, then the
		// sender pauses until every record has come back
		write_limit(CountW'(SLOTS_TOP));
		frame_gap_max  = 0;
		record_gap_max = 0;
		send_random(75);
		wait_idle();
		frame_gap_max  = IDLE_MAX;
		record_gap_max = IDLE_MAX;
		send_random(75);

		// just under the slot count, counters resume above the earlier limits
		write_limit(CountW'(SLOTS_TOP - 1));
		send_random(225);

		wait_idle();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
